// ===== rtl/core/mcorb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcorb_pkg
// Shared types, constants and helpers of the multi-channel overwrite ring
// buffer: command and status codes, register indexes, widths.
// ----------------------------------------------------------------------------
package mcorb_pkg;

  localparam int NUM_CHANNELS  = 4;
  localparam int MAX_LOG_DEPTH = 8;
  localparam int DATA_WIDTH    = 32;

  localparam int CHAN_W  = $clog2(NUM_CHANNELS);
  localparam int IDX_W   = MAX_LOG_DEPTH;
  localparam int CNT_W   = MAX_LOG_DEPTH + 1;
  localparam int ADDR_W  = CHAN_W + IDX_W;
  localparam int LDEP_W  = 4;
  localparam int LEB_W   = 2;
  localparam int CFG_W   = 4;
  localparam int CFGIX_W = 2;

  // configuration register indexes
  localparam logic [CFGIX_W-1:0] CFG_LOG_DEPTH      = 2'd0;
  localparam logic [CFGIX_W-1:0] CFG_LOG_ELEM_BYTES = 2'd1;
  localparam logic [CFGIX_W-1:0] CFG_ENABLE_MASK    = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_DISABLED  = 2'd2
  } status_e;

  // element store request issued at accept
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
  } ram_req_t;

  // per-request result fields known at accept
  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] cap;
    logic             en;
    logic             rd_ok;
  } resp_t;

  // element width mask, size code 3 acts as 4 bytes
  function automatic logic [DATA_WIDTH-1:0] elem_mask(input logic [LEB_W-1:0] leb);
    logic [DATA_WIDTH-1:0] m;
    m = '1;
    case (leb)
      2'd0:    m = DATA_WIDTH'(8'hFF);
      2'd1:    m = DATA_WIDTH'(16'hFFFF);
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/mcorb_store_ram.sv =====
// ----------------------------------------------------------------------------
// mcorb_store_ram
// Single-port synchronous element store, registered read data that holds
// until the next read.
// ----------------------------------------------------------------------------
module mcorb_store_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mcorb_ptr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcorb_ptr_ctrl
// Per-channel read index, write index and fill count. Decodes each accepted
// request, updates the channel pointers and issues the element store access.
// ----------------------------------------------------------------------------
module mcorb_ptr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    command_i,
  input  logic [mcorb_pkg::CHAN_W-1:0]  sel_i,
  input  logic [mcorb_pkg::LDEP_W-1:0]  log_depth_i,
  input  logic [mcorb_pkg::CFG_W-1:0]   enable_mask_i,
  output mcorb_pkg::ram_req_t           ram_req_o,
  output mcorb_pkg::resp_t              resp_o
);
  import mcorb_pkg::*;

  logic [IDX_W-1:0] wr_idx_q [NUM_CHANNELS];
  logic [IDX_W-1:0] rd_idx_q [NUM_CHANNELS];
  logic [CNT_W-1:0] cnt_q    [NUM_CHANNELS];

  logic [IDX_W-1:0] wr_idx_d, rd_idx_d;
  logic [CNT_W-1:0] cnt_d;
  logic [LDEP_W-1:0] eff_ld;
  logic [CNT_W-1:0] cap;
  logic [IDX_W-1:0] imask;
  logic [IDX_W-1:0] w_cur, r_cur;
  logic [CNT_W-1:0] cnt_cur;
  logic             en;
  logic             upd;

  // capacity from saturated depth
  always_comb begin
    eff_ld = (log_depth_i > LDEP_W'(MAX_LOG_DEPTH)) ? LDEP_W'(MAX_LOG_DEPTH) : log_depth_i;
    cap    = CNT_W'(1) << eff_ld;
    imask  = IDX_W'(cap - CNT_W'(1));
  end

  // command decode and pointer next state
  always_comb begin
    w_cur    = wr_idx_q[sel_i] & imask;
    r_cur    = rd_idx_q[sel_i] & imask;
    cnt_cur  = cnt_q[sel_i];
    en       = enable_mask_i[sel_i];
    wr_idx_d = wr_idx_q[sel_i];
    rd_idx_d = rd_idx_q[sel_i];
    cnt_d    = cnt_cur;
    upd      = 1'b0;
    ram_req_o        = '0;
    resp_o.status    = ST_OK;
    resp_o.rd_ok     = 1'b0;
    if (!en) begin
      resp_o.status = ST_DISABLED;
    end else begin
      unique case (cmd_e'(command_i))
        CMD_WRITE: begin
          upd            = 1'b1;
          ram_req_o.we   = 1'b1;
          ram_req_o.addr = {sel_i, w_cur};
          wr_idx_d       = (w_cur + IDX_W'(1)) & imask;
          if (cnt_cur >= cap) begin
            rd_idx_d = (r_cur + IDX_W'(1)) & imask;
            cnt_d    = cap;
          end else begin
            cnt_d = cnt_cur + CNT_W'(1);
          end
        end
        CMD_READ: begin
          if (cnt_cur == '0) begin
            resp_o.status = ST_UNDERFLOW;
          end else begin
            upd            = 1'b1;
            ram_req_o.re   = 1'b1;
            ram_req_o.addr = {sel_i, r_cur};
            rd_idx_d       = (r_cur + IDX_W'(1)) & imask;
            cnt_d          = cnt_cur - CNT_W'(1);
            resp_o.rd_ok   = 1'b1;
          end
        end
        CMD_FLUSH: begin
          upd      = 1'b1;
          wr_idx_d = '0;
          rd_idx_d = '0;
          cnt_d    = '0;
        end
        default: begin
          upd = 1'b0;
        end
      endcase
    end
    ram_req_o.we &= accept_i;
    ram_req_o.re &= accept_i;
    resp_o.fill  = cnt_d;
    resp_o.cap   = cap;
    resp_o.en    = en;
  end

  // pointer file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        wr_idx_q[c] <= '0;
        rd_idx_q[c] <= '0;
        cnt_q[c]    <= '0;
      end
    end else if (accept_i && upd) begin
      wr_idx_q[sel_i] <= wr_idx_d;
      rd_idx_q[sel_i] <= rd_idx_d;
      cnt_q[sel_i]    <= cnt_d;
    end
  end

  // fill count never passes the largest capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[sel_i] <= CNT_W'(1 << MAX_LOG_DEPTH))
    else $error("fill count above maximum capacity");

  // one store access per request
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.we && ram_req_o.re))
    else $error("store read and write in the same cycle");

  // a flush leaves the channel empty
  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && en && command_i == CMD_FLUSH |=> cnt_q[$past(sel_i)] == '0)
    else $error("flush did not empty the channel");

endmodule

// ===== rtl/core/multi_channel_overwrite_ring_buffer_top.sv =====
// ----------------------------------------------------------------------------
// multi_channel_overwrite_ring_buffer_top
// Four ring buffers sharing one element store; a full buffer drops its
// oldest element on write.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  command, buffer_select, write_data
//   out      output     out_valid_o/out_ready_i status, read_data, fill_count,
//                                              capacity, enabled
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One request per cycle while the output is not stalled; a result passes
// through the store read stage and then the output register.
// Pointers update at accept, so a following request on the same channel
// sees them at once; the store read register holds across stalls.
// Reset clears all pointers and counts; the element store is not cleared.
// A stalled output stalls the store stage and then the input.
// ----------------------------------------------------------------------------
module multi_channel_overwrite_ring_buffer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic [mcorb_pkg::CHAN_W-1:0]      buffer_select_i,
  input  logic [mcorb_pkg::DATA_WIDTH-1:0]  write_data_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [mcorb_pkg::DATA_WIDTH-1:0]  read_data_o,
  output logic [mcorb_pkg::CNT_W-1:0]       fill_count_o,
  output logic [mcorb_pkg::CNT_W-1:0]       capacity_o,
  output logic                              enabled_o,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [mcorb_pkg::CFGIX_W-1:0]     cfg_idx_i,
  input  logic [mcorb_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import mcorb_pkg::*;

  logic [LDEP_W-1:0]     log_depth_q;
  logic [LEB_W-1:0]      log_elem_bytes_q;
  logic [CFG_W-1:0]      enable_mask_q;

  logic                  accept;
  logic                  s1_adv;
  logic                  s1_valid_q;
  resp_t                 s1_resp_q;
  logic [DATA_WIDTH-1:0] s1_emask_q;
  logic                  out_valid_q;
  resp_t                 out_resp_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic [DATA_WIDTH-1:0] emask;
  logic [DATA_WIDTH-1:0] ram_rdata;
  ram_req_t              ram_req;
  resp_t                 resp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_depth_q      <= LDEP_W'(4);
      log_elem_bytes_q <= '0;
      enable_mask_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOG_DEPTH:      log_depth_q      <= cfg_wdata_i;
        CFG_LOG_ELEM_BYTES: log_elem_bytes_q <= cfg_wdata_i[LEB_W-1:0];
        CFG_ENABLE_MASK:    enable_mask_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign emask = elem_mask(log_elem_bytes_q);

  // handshake
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  mcorb_ptr_ctrl u_ptr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .command_i     (command_i),
    .sel_i         (buffer_select_i),
    .log_depth_i   (log_depth_q),
    .enable_mask_i (enable_mask_q),
    .ram_req_o     (ram_req),
    .resp_o        (resp)
  );

  mcorb_store_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (write_data_i & emask),
    .rdata_o (ram_rdata)
  );

  // store stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // store stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_resp_q  <= resp;
      s1_emask_q <= emask;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_resp_q <= s1_resp_q;
      out_data_q <= s1_resp_q.rd_ok ? (ram_rdata & s1_emask_q) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_resp_q.status;
  assign read_data_o  = out_data_q;
  assign fill_count_o = out_resp_q.fill;
  assign capacity_o   = out_resp_q.cap;
  assign enabled_o    = out_resp_q.en;

  // a stalled output keeps the store stage occupied
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q)
    else $error("store stage lost a request under stall");

  // only a successful read carries data
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_data_o == '0)
    else $error("data on a failed request");

  // a disabled channel is always refused
  a_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !enabled_o |-> status_o == ST_DISABLED)
    else $error("disabled channel not refused");

endmodule
